FILE: rtl/ffha_pkg.sv
// Shared constants, codes and types of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;
	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 24;
	localparam int ALIGN_LG     = 4;
	localparam int ALIGN_BYTES  = 1 << ALIGN_LG;
	localparam int IDX_W        = $clog2(MAX_BLOCKS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int ADDR_W       = 48;
	localparam int LEN_W        = 32;

	typedef enum logic [1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_INIT  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_DONE = 2'd0,
		STAT_FAIL = 2'd1,
		STAT_IGN  = 2'd2
	} stat_t;

	typedef enum logic {
		CFG_START  = 1'b0,
		CFG_LENGTH = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic             used;
		logic [LEN_W-1:0] off;
		logic [LEN_W-1:0] size;
	} ent_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		ent_t             data;
	} wr_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  free;
		logic [LEN_W-1:0]  heap;
	} res_t;
endpackage
`default_nettype wire

FILE: rtl/ffha_table.sv
// Block table memory: one write port, one registered read port.
`default_nettype none
module ffha_table import ffha_pkg::*; (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	input  wire wr_t              wr,
	output ent_t                  rd_data
);
	ent_t mem [MAX_BLOCKS];

	// write the entry
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// register the read word
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/ffha_ctrl.sv
// Sequencer: initialise, search, split, release and merge over the block table.
`default_nettype none
module ffha_ctrl import ffha_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   busy,
	input  wire logic [1:0]        kind,
	input  wire logic [LEN_W-1:0]  request_bytes,
	input  wire logic [ADDR_W-1:0] release_address,
	input  wire logic [ADDR_W-1:0] cfg_start,
	input  wire logic [LEN_W-1:0]  cfg_length,
	output logic                   res_valid,
	input  wire logic              res_take,
	output res_t                   res
);
	typedef enum logic [16:0] {
		S_IDLE = 17'h00001,
		S_ARD  = 17'h00002,
		S_ACHK = 17'h00004,
		S_UPRD = 17'h00008,
		S_UPWR = 17'h00010,
		S_SPL1 = 17'h00020,
		S_SPL2 = 17'h00040,
		S_RRD  = 17'h00080,
		S_RCHK = 17'h00100,
		S_MP   = 17'h00200,
		S_MPW  = 17'h00400,
		S_MN   = 17'h00800,
		S_MNW  = 17'h01000,
		S_MAPP = 17'h02000,
		S_DRD  = 17'h04000,
		S_DWR  = 17'h08000,
		S_DONE = 17'h10000
	} state_t;

	localparam logic [LEN_W-1:0] HDR = LEN_W'(HEADER_BYTES);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  idx_q, idx_d, cnt_q, cnt_d, found_q, found_d;
	logic              hit_q, hit_d, hp_q, hp_d, hn_q, hn_d;
	logic [1:0]        k_q, k_d, status_q, status_d;
	ent_t              ent_q, ent_d, prv_q, prv_d, nxt_q, nxt_d;
	logic [LEN_W:0]    size_q, size_d;
	logic [LEN_W-1:0]  rest_q, rest_d, free_q, free_d, total_q, total_d;
	logic [ADDR_W-1:0] tgt_q, tgt_d, base_q, base_d, limit_q, limit_d;
	logic [ADDR_W-1:0] addr_q, addr_d;

	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	wr_t               wr;
	ent_t              rd_data;

	logic [LEN_W:0]    req_up;
	logic              fit, split;
	logic [LEN_W-1:0]  rest_w;
	logic              rel_bad;
	logic [ADDR_W:0]   base_up, base_al, end_raw, end_cl, lim_al;
	logic [ADDR_W+1:0] base_hdr;
	logic              init_empty;
	logic [LEN_W-1:0]  init_total;
	logic              pf, nf;

	ffha_table u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rd_data (rd_data)
	);

	function automatic logic [ADDR_W-1:0] grant(input logic [ADDR_W-1:0] b,
		input logic [LEN_W-1:0] off);
		grant = b + {{(ADDR_W-LEN_W){1'b0}}, off} + ADDR_W'(HEADER_BYTES);
	endfunction

	// round the request up to the alignment
	always_comb begin
		req_up = {1'b0, request_bytes} + (LEN_W+1)'(ALIGN_BYTES - 1);
		req_up[ALIGN_LG-1:0] = '0;
	end

	// fit test of the word read during the search
	assign fit    = !rd_data.used && ({1'b0, rd_data.size} >= size_q);
	assign rest_w = rd_data.size - size_q[LEN_W-1:0];
	assign split  = (rest_w > LEN_W'(HEADER_BYTES + ALIGN_BYTES))
		&& (cnt_q < CNT_W'(MAX_BLOCKS));

	// release address range check
	assign rel_bad = (release_address == '0)
		|| ({1'b0, release_address} < ({1'b0, base_q} + (ADDR_W+1)'(HEADER_BYTES)))
		|| (release_address >= limit_q);

	// align the configured region inward
	always_comb begin
		base_up = {1'b0, cfg_start} + (ADDR_W+1)'(ALIGN_BYTES - 1);
		base_al = base_up;
		base_al[ALIGN_LG-1:0] = '0;
		end_raw = {1'b0, cfg_start} + {{(ADDR_W+1-LEN_W){1'b0}}, cfg_length};
		end_cl  = end_raw[ADDR_W] ? {1'b1, {ADDR_W{1'b0}}} : end_raw;
		lim_al  = end_cl;
		lim_al[ALIGN_LG-1:0] = '0;
		base_hdr = {1'b0, base_al} + (ADDR_W+2)'(HEADER_BYTES);
		init_empty = (cfg_start == '0) || (cfg_length <= HDR) || base_al[ADDR_W]
			|| ({1'b0, lim_al} <= base_hdr);
		init_total = lim_al[LEN_W-1:0] - base_al[LEN_W-1:0];
	end

	assign pf = hp_q && !prv_q.used;
	assign nf = hn_q && !nxt_q.used;

	// next state and table accesses
	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		found_d  = found_q;
		hit_d    = hit_q;
		hp_d     = hp_q;
		hn_d     = hn_q;
		k_d      = k_q;
		status_d = status_q;
		ent_d    = ent_q;
		prv_d    = prv_q;
		nxt_d    = nxt_q;
		size_d   = size_q;
		rest_d   = rest_q;
		free_d   = free_q;
		total_d  = total_q;
		tgt_d    = tgt_q;
		base_d   = base_q;
		limit_d  = limit_q;
		addr_d   = addr_q;
		rd_en    = 1'b0;
		rd_addr  = idx_q[IDX_W-1:0];
		wr       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					addr_d   = '0;
					status_d = STAT_DONE;
					idx_d    = '0;
					hit_d    = 1'b0;
					state_d  = S_DONE;
					case (kind)
						KIND_ALLOC: begin
							size_d = req_up;
							if (request_bytes == '0 || cnt_q == '0) begin
								status_d = STAT_FAIL;
							end else begin
								state_d = S_ARD;
							end
						end
						KIND_FREE: begin
							tgt_d = release_address - base_q - ADDR_W'(HEADER_BYTES);
							if (rel_bad) begin
								status_d = STAT_IGN;
							end else begin
								state_d = S_RRD;
							end
						end
						KIND_INIT: begin
							if (init_empty) begin
								cnt_d   = '0;
								base_d  = '0;
								limit_d = '0;
								total_d = '0;
								free_d  = '0;
							end else begin
								cnt_d   = CNT_W'(1);
								base_d  = base_al[ADDR_W-1:0];
								limit_d = lim_al[ADDR_W-1:0];
								total_d = init_total;
								free_d  = init_total - HDR;
								wr.en   = 1'b1;
								wr.addr = '0;
								wr.data = '{used: 1'b0, off: '0, size: init_total - HDR};
							end
						end
						default: begin
							status_d = STAT_IGN;
						end
					endcase
				end
			end
			// first-fit search
			S_ARD: begin
				if (idx_q == cnt_q) begin
					status_d = STAT_FAIL;
					state_d  = S_DONE;
				end else begin
					rd_en   = 1'b1;
					state_d = S_ACHK;
				end
			end
			S_ACHK: begin
				if (fit) begin
					ent_d   = rd_data;
					found_d = idx_q;
					rest_d  = rest_w;
					if (split) begin
						idx_d   = cnt_q;
						state_d = S_UPRD;
					end else begin
						wr.en   = 1'b1;
						wr.addr = idx_q[IDX_W-1:0];
						wr.data = '{used: 1'b1, off: rd_data.off, size: rd_data.size};
						free_d  = free_q - rd_data.size;
						addr_d  = grant(base_q, rd_data.off);
						state_d = S_DONE;
					end
				end else begin
					idx_d   = idx_q + CNT_W'(1);
					state_d = S_ARD;
				end
			end
			// open a hole behind the split block
			S_UPRD: begin
				if (idx_q == found_q + CNT_W'(1)) begin
					state_d = S_SPL1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(idx_q - CNT_W'(1));
					state_d = S_UPWR;
				end
			end
			S_UPWR: begin
				wr.en   = 1'b1;
				wr.addr = idx_q[IDX_W-1:0];
				wr.data = rd_data;
				idx_d   = idx_q - CNT_W'(1);
				state_d = S_UPRD;
			end
			S_SPL1: begin
				wr.en   = 1'b1;
				wr.addr = IDX_W'(found_q + CNT_W'(1));
				wr.data = '{used: 1'b0, off: ent_q.off + HDR + size_q[LEN_W-1:0],
					size: rest_q - HDR};
				state_d = S_SPL2;
			end
			S_SPL2: begin
				wr.en   = 1'b1;
				wr.addr = found_q[IDX_W-1:0];
				wr.data = '{used: 1'b1, off: ent_q.off, size: size_q[LEN_W-1:0]};
				cnt_d   = cnt_q + CNT_W'(1);
				free_d  = free_q - size_q[LEN_W-1:0] - HDR;
				addr_d  = grant(base_q, ent_q.off);
				state_d = S_DONE;
			end
			// look for the released block
			S_RRD: begin
				if (idx_q == cnt_q) begin
					if (hit_q) begin
						state_d = S_MP;
					end else begin
						status_d = STAT_IGN;
						state_d  = S_DONE;
					end
				end else begin
					rd_en   = 1'b1;
					state_d = S_RCHK;
				end
			end
			S_RCHK: begin
				if ({{(ADDR_W-LEN_W){1'b0}}, rd_data.off} == tgt_q) begin
					hit_d   = 1'b1;
					found_d = idx_q;
					ent_d   = rd_data;
				end
				idx_d   = idx_q + CNT_W'(1);
				state_d = S_RRD;
			end
			// fetch the neighbours
			S_MP: begin
				if (found_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(found_q - CNT_W'(1));
					hp_d    = 1'b1;
					state_d = S_MPW;
				end else begin
					hp_d    = 1'b0;
					state_d = S_MN;
				end
			end
			S_MPW: begin
				prv_d   = rd_data;
				state_d = S_MN;
			end
			S_MN: begin
				if (found_q + CNT_W'(1) < cnt_q) begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(found_q + CNT_W'(1));
					hn_d    = 1'b1;
					state_d = S_MNW;
				end else begin
					hn_d    = 1'b0;
					state_d = S_MAPP;
				end
			end
			S_MNW: begin
				nxt_d   = rd_data;
				state_d = S_MAPP;
			end
			// merge with free neighbours
			S_MAPP: begin
				free_d = free_q + (ent_q.used ? ent_q.size : '0)
					+ (pf ? HDR : '0) + (nf ? HDR : '0);
				wr.en  = 1'b1;
				if (pf) begin
					wr.addr = IDX_W'(found_q - CNT_W'(1));
					wr.data = '{used: 1'b0, off: prv_q.off,
						size: prv_q.size + HDR + ent_q.size + (nf ? HDR + nxt_q.size : '0)};
					idx_d   = found_q;
					k_d     = nf ? 2'd2 : 2'd1;
					state_d = S_DRD;
				end else if (nf) begin
					wr.addr = found_q[IDX_W-1:0];
					wr.data = '{used: 1'b0, off: ent_q.off,
						size: ent_q.size + HDR + nxt_q.size};
					idx_d   = found_q + CNT_W'(1);
					k_d     = 2'd1;
					state_d = S_DRD;
				end else begin
					wr.addr = found_q[IDX_W-1:0];
					wr.data = '{used: 1'b0, off: ent_q.off, size: ent_q.size};
					state_d = S_DONE;
				end
			end
			// close the gap left by merged blocks
			S_DRD: begin
				if ({1'b0, idx_q} + (CNT_W+1)'(k_q) >= {1'b0, cnt_q}) begin
					cnt_d   = cnt_q - CNT_W'(k_q);
					state_d = S_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(idx_q + CNT_W'(k_q));
					state_d = S_DWR;
				end
			end
			S_DWR: begin
				wr.en   = 1'b1;
				wr.addr = idx_q[IDX_W-1:0];
				wr.data = rd_data;
				idx_d   = idx_q + CNT_W'(1);
				state_d = S_DRD;
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			base_q  <= '0;
			limit_q <= '0;
			total_q <= '0;
			free_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			base_q  <= base_d;
			limit_q <= limit_d;
			total_q <= total_d;
			free_q  <= free_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		found_q  <= found_d;
		hit_q    <= hit_d;
		hp_q     <= hp_d;
		hn_q     <= hn_d;
		k_q      <= k_d;
		status_q <= status_d;
		ent_q    <= ent_d;
		prv_q    <= prv_d;
		nxt_q    <= nxt_d;
		size_q   <= size_d;
		rest_q   <= rest_d;
		tgt_q    <= tgt_d;
		addr_q   <= addr_d;
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = '{status: status_q, addr: addr_q, free: free_q, heap: total_q};
endmodule
`default_nettype wire

FILE: rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: configuration, sequencer, result register.
//
// Keeps an address-ordered table of up to 64 heap blocks in a single-port-read
// synchronous memory and serves allocate, release and initialise words, one at a time,
// each giving one result word. Every table access is an address state followed by
// registered data. An allocate searches the blocks up to the first fit and moves
// blocks on a split; a release scans every block and moves blocks on a merge; an
// initialise writes at most one entry. The next input word is taken while a result
// still waits in the output register. Registers must be written only while the block
// is idle; the block itself does not enforce it. cfg_ready is always high.
`default_nettype none
module first_fit_heap_allocator import ffha_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [ADDR_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        kind,
	input  wire logic [LEN_W-1:0]  request_bytes,
	input  wire logic [ADDR_W-1:0] release_address,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             status,
	output logic [ADDR_W-1:0]      payload_address,
	output logic [LEN_W-1:0]       free_total,
	output logic [LEN_W-1:0]       heap_bytes
);
	logic [ADDR_W-1:0] start_q;
	logic [LEN_W-1:0]  length_q;
	logic              busy, res_valid, res_take, out_valid_q;
	res_t              res, out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			length_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_START:  start_q  <= cfg_data;
				CFG_LENGTH: length_q <= cfg_data[LEN_W-1:0];
				default:    start_q  <= start_q;
			endcase
		end
	end

	ffha_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.busy            (busy),
		.kind            (kind),
		.request_bytes   (request_bytes),
		.release_address (release_address),
		.cfg_start       (start_q),
		.cfg_length      (length_q),
		.res_valid       (res_valid),
		.res_take        (res_take),
		.res             (res)
	);

	// load the result word when the output register is free or draining
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign cfg_ready       = 1'b1;
	assign in_stall        = busy;
	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign payload_address = out_q.addr;
	assign free_total      = out_q.free;
	assign heap_bytes      = out_q.heap;
endmodule
`default_nettype wire
